// ===== rtl/mtfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtfp_pkg;

    // Function codes that the parser decodes.
    localparam logic [7:0] FC_READ_COILS      = 8'h01;
    localparam logic [7:0] FC_READ_INPUTS     = 8'h02;
    localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
    localparam logic [7:0] FC_READ_INPUT_REGS = 8'h04;
    localparam logic [7:0] FC_WRITE_COIL      = 8'h05;
    localparam logic [7:0] FC_WRITE_REG       = 8'h06;
    localparam logic [7:0] FC_READ_EXC_STATUS = 8'h07;
    localparam logic [7:0] FC_WRITE_COILS     = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS      = 8'h10;

    localparam logic [15:0] COIL_ON_VALUE     = 16'hFF00;
    localparam logic [7:0]  DIAG_FAULT_VALUE  = 8'hFF;

    // Minimum frame: MBAP header plus function code.
    localparam logic [16:0] MIN_FRAME_BYTES   = 17'd8;
    localparam logic [16:0] MBAP_PREFIX_BYTES = 17'd6;
    localparam logic [16:0] FIRST_DATA_POS    = 17'd9;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT    = 2'd1;
    localparam logic [1:0] ST_BAD_PROTOCOL = 2'd2;
    localparam logic [1:0] ST_LEN_MISMATCH = 2'd3;

    localparam logic [1:0] CLASS_OFF_NORMAL = 2'd0;
    localparam logic [1:0] CLASS_ON_FAULT   = 2'd1;
    localparam logic [1:0] CLASS_UNKNOWN    = 2'd2;

    localparam logic KIND_ELEMENT = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        record_kind;
        logic [1:0]  status;
        logic [15:0] transaction_id;
        logic [15:0] pdu_length;
        logic [7:0]  unit_id;
        logic [7:0]  function_code;
        logic [7:0]  exception_code;
        logic [15:0] address;
        logic [15:0] value;
        logic [15:0] data_length;
        logic [1:0]  value_class;
        logic        last;
    } t_rec;

endpackage

`default_nettype wire

// ===== rtl/modbus_tcp_frame_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Modbus TCP frame parser. Frame bytes enter on the input channel
// (i_in_valid / o_in_stall), one byte per beat, with i_frame_end set on the
// last byte of each frame. Records leave on the output channel
// (o_out_valid / i_out_stall), one record per beat.
// A coil byte (codes 1 and 2) or a completed register word (codes 3 and 4)
// gives a provisional element record; the frame_end byte gives a summary
// record with status and decoded fields, after any element record of the
// same byte. o_last marks the final record caused by one input byte.
// A record is registered into the queue when its byte is accepted.
// Throughput: one byte per cycle while o_in_stall is low; all decoding
// is one combinational pass from the capture registers into a four-entry
// record queue. A byte that yields two records occupies two queue slots,
// so a run of such bytes is limited by the one-record-per-cycle output
// port. o_in_stall is high while fewer than two queue slots are free, so the
// receiver stalling for long fills the queue and then holds off the input.
// Reset clears the frame capture state, the byte counter and the queue.

module modbus_tcp_frame_parser_top
    import mtfp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_frame_end,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_record_kind,
    output logic [1:0]       o_status,
    output logic [15:0]      o_transaction_id,
    output logic [15:0]      o_pdu_length,
    output logic [7:0]       o_unit_id,
    output logic [7:0]       o_function_code,
    output logic [7:0]       o_exception_code,
    output logic [15:0]      o_address,
    output logic [15:0]      o_value,
    output logic [15:0]      o_data_length,
    output logic [1:0]       o_value_class,
    output logic             o_last
);

    localparam logic [16:0] POS_MAX = '1;

    // Frame capture state.
    logic [16:0] r_pos, n_pos;
    logic [15:0] r_trans, n_trans;
    logic [15:0] r_proto, n_proto;
    logic [15:0] r_len, n_len;
    logic [7:0]  r_unit, n_unit;
    logic [7:0]  r_func, n_func;
    logic [7:0]  r_fpay, n_fpay;
    logic [15:0] r_addr, n_addr;
    logic [15:0] r_word, n_word;
    logic [7:0]  r_pend, n_pend;
    logic [7:0]  r_elem, n_elem;

    // Record queue.
    t_rec       r_q [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    logic        in_acc;
    logic        out_acc;
    logic        emit;
    logic [16:0] off;
    logic [15:0] elem_value;
    logic [1:0]  st;
    logic [2:0]  push_n;
    t_rec        rec_elem;
    t_rec        rec_sum;
    t_rec        head;

    assign o_in_stall  = (r_count > 3'd2);
    assign o_out_valid = (r_count != 3'd0);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;

    always_comb begin
        n_trans = r_trans;
        n_proto = r_proto;
        n_len   = r_len;
        n_unit  = r_unit;
        n_func  = r_func;
        n_fpay  = r_fpay;
        n_addr  = r_addr;
        n_word  = r_word;
        n_pend  = r_pend;

        case (r_pos)
            17'd0, 17'd1: n_trans = {r_trans[7:0], i_data_byte};
            17'd2, 17'd3: n_proto = {r_proto[7:0], i_data_byte};
            17'd4, 17'd5: n_len   = {r_len[7:0], i_data_byte};
            17'd6:        n_unit  = i_data_byte;
            17'd7:        n_func  = i_data_byte;
            17'd8: begin
                n_fpay = i_data_byte;
                n_addr = {i_data_byte, 8'd0};
            end
            17'd9:        n_addr  = {r_addr[15:8], i_data_byte};
            17'd10:       n_word  = {i_data_byte, 8'd0};
            17'd11:       n_word  = {r_word[15:8], i_data_byte};
            default:      ;
        endcase

        // Element records: offset counts from the first data byte (byte 9).
        off        = r_pos - FIRST_DATA_POS;
        emit       = 1'b0;
        elem_value = 16'd0;
        if (r_pos >= FIRST_DATA_POS) begin
            if (n_func == FC_READ_COILS || n_func == FC_READ_INPUTS) begin
                if (off < {9'd0, n_fpay}) begin
                    emit       = 1'b1;
                    elem_value = {8'd0, i_data_byte};
                end
            end else if (n_func == FC_READ_HOLDING || n_func == FC_READ_INPUT_REGS) begin
                if (!off[0]) begin
                    n_pend = i_data_byte;
                end else if (off[16:1] < {9'd0, n_fpay[7:1]}) begin
                    emit       = 1'b1;
                    elem_value = {r_pend, i_data_byte};
                end
            end
        end
        n_elem = emit ? r_elem + 8'd1 : r_elem;

        n_pos = (r_pos != POS_MAX) ? r_pos + 17'd1 : r_pos;

        rec_elem                = '0;
        rec_elem.record_kind    = KIND_ELEMENT;
        rec_elem.transaction_id = n_trans;
        rec_elem.pdu_length     = n_len;
        rec_elem.unit_id        = n_unit;
        rec_elem.function_code  = n_func;
        rec_elem.address        = {8'd0, r_elem};
        rec_elem.value          = elem_value;
        rec_elem.last           = !i_frame_end;

        if (n_pos < MIN_FRAME_BYTES) begin
            st = ST_TOO_SHORT;
        end else if (n_proto != 16'd0) begin
            st = ST_BAD_PROTOCOL;
        end else if (n_pos != MBAP_PREFIX_BYTES + {1'b0, n_len}) begin
            st = ST_LEN_MISMATCH;
        end else begin
            st = ST_OK;
        end

        rec_sum                = '0;
        rec_sum.record_kind    = KIND_SUMMARY;
        rec_sum.status         = st;
        rec_sum.transaction_id = n_trans;
        rec_sum.pdu_length     = n_len;
        rec_sum.unit_id        = n_unit;
        rec_sum.function_code  = n_func;
        rec_sum.last           = 1'b1;
        if (st == ST_OK) begin
            if (n_func[7]) begin
                rec_sum.exception_code = n_fpay;
            end else begin
                unique case (n_func) inside
                    FC_READ_COILS, FC_READ_INPUTS: begin
                        rec_sum.data_length = {5'd0, n_fpay, 3'd0};
                    end
                    FC_READ_HOLDING, FC_READ_INPUT_REGS: begin
                        rec_sum.data_length = {9'd0, n_fpay[7:1]};
                    end
                    FC_WRITE_COIL: begin
                        rec_sum.address     = n_addr;
                        rec_sum.value       = n_word;
                        rec_sum.value_class = (n_word == COIL_ON_VALUE) ?
                                              CLASS_ON_FAULT : CLASS_OFF_NORMAL;
                    end
                    FC_WRITE_REG: begin
                        rec_sum.address = n_addr;
                        rec_sum.value   = n_word;
                    end
                    FC_READ_EXC_STATUS: begin
                        rec_sum.value = {8'd0, n_fpay};
                        if (n_fpay == 8'd0) begin
                            rec_sum.value_class = CLASS_OFF_NORMAL;
                        end else if (n_fpay == DIAG_FAULT_VALUE) begin
                            rec_sum.value_class = CLASS_ON_FAULT;
                        end else begin
                            rec_sum.value_class = CLASS_UNKNOWN;
                        end
                    end
                    FC_WRITE_COILS, FC_WRITE_REGS: begin
                        rec_sum.address     = n_addr;
                        rec_sum.data_length = n_word;
                    end
                    default: ;
                endcase
            end
        end

        push_n = in_acc ? ({2'd0, emit} + {2'd0, i_frame_end}) : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_trans  <= '0;
            r_proto  <= '0;
            r_len    <= '0;
            r_unit   <= '0;
            r_func   <= '0;
            r_fpay   <= '0;
            r_addr   <= '0;
            r_word   <= '0;
            r_pend   <= '0;
            r_elem   <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_acc) begin
                r_pend <= n_pend;
                if (i_frame_end) begin
                    r_pos   <= '0;
                    r_trans <= '0;
                    r_proto <= '0;
                    r_len   <= '0;
                    r_unit  <= '0;
                    r_func  <= '0;
                    r_fpay  <= '0;
                    r_addr  <= '0;
                    r_word  <= '0;
                    r_elem  <= '0;
                end else begin
                    r_pos   <= n_pos;
                    r_trans <= n_trans;
                    r_proto <= n_proto;
                    r_len   <= n_len;
                    r_unit  <= n_unit;
                    r_func  <= n_func;
                    r_fpay  <= n_fpay;
                    r_addr  <= n_addr;
                    r_word  <= n_word;
                    r_elem  <= n_elem;
                end
            end
            r_wr_ptr <= r_wr_ptr + push_n[1:0];
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + push_n - {2'd0, out_acc};
        end
    end

    // Queue payload: an element record always goes ahead of the summary.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (emit) begin
                r_q[r_wr_ptr] <= rec_elem;
                if (i_frame_end) begin
                    r_q[r_wr_ptr + 2'd1] <= rec_sum;
                end
            end else if (i_frame_end) begin
                r_q[r_wr_ptr] <= rec_sum;
            end
        end
    end

    assign head             = r_q[r_rd_ptr];
    assign o_record_kind    = head.record_kind;
    assign o_status         = head.status;
    assign o_transaction_id = head.transaction_id;
    assign o_pdu_length     = head.pdu_length;
    assign o_unit_id        = head.unit_id;
    assign o_function_code  = head.function_code;
    assign o_exception_code = head.exception_code;
    assign o_address        = head.address;
    assign o_value          = head.value;
    assign o_data_length    = head.data_length;
    assign o_value_class    = head.value_class;
    assign o_last           = head.last;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

import mtfp_pkg::*;

// Function codes at and above this value are exception responses.
localparam logic [7:0] FC_EXCEPTION_BASE = 8'h80;

class mbap_checker;
    logic [16:0] byte_count;
    logic [15:0] txn_id;
    logic [15:0] proto_id;
    logic [15:0] mbap_len;
    logic [7:0]  unit;
    logic [7:0]  fcode;
    logic [7:0]  count_byte;
    logic [15:0] addr_word;
    logic [15:0] data_word;
    logic [7:0]  high_byte;
    logic [7:0]  elem_idx;
    t_rec        due_records[$];
    int          mismatches;

    function new();
        mismatches = 0;
        high_byte = '0;
        start_frame();
    endfunction

    function void start_frame();
        byte_count = '0;
        txn_id = '0;
        proto_id = '0;
        mbap_len = '0;
        unit = '0;
        fcode = '0;
        count_byte = '0;
        addr_word = '0;
        data_word = '0;
        elem_idx = '0;
    endfunction

    function void put_header(ref t_rec rec);
        rec.transaction_id = txn_id;
        rec.pdu_length = mbap_len;
        rec.unit_id = unit;
        rec.function_code = fcode;
    endfunction

    // Works out the records that one accepted beat causes.
    function void take_byte(logic [7:0] b, logic fe);
        t_rec        rec;
        int unsigned slot;
        int unsigned total;
        logic        hit;
        logic [15:0] elem_val;
        hit = 1'b0;
        elem_val = '0;
        case (byte_count)
            17'd0, 17'd1: txn_id = {txn_id[7:0], b};
            17'd2, 17'd3: proto_id = {proto_id[7:0], b};
            17'd4, 17'd5: mbap_len = {mbap_len[7:0], b};
            17'd6: unit = b;
            17'd7: fcode = b;
            17'd8: begin
                count_byte = b;
                addr_word = {b, 8'h00};
            end
            17'd9: addr_word[7:0] = b;
            17'd10: data_word = {b, 8'h00};
            17'd11: data_word[7:0] = b;
            default: ;
        endcase

        if (byte_count >= FIRST_DATA_POS) begin
            slot = byte_count - FIRST_DATA_POS;
            if (fcode == FC_READ_COILS || fcode == FC_READ_INPUTS) begin
                if (slot < count_byte) begin
                    hit = 1'b1;
                    elem_val = {8'h00, b};
                end
            end else if (fcode == FC_READ_HOLDING || fcode == FC_READ_INPUT_REGS) begin
                if (!slot[0]) begin
                    high_byte = b;
                end else if ((slot >> 1) < (count_byte >> 1)) begin
                    hit = 1'b1;
                    elem_val = {high_byte, b};
                end
            end
        end

        if (hit) begin
            rec = '0;
            rec.record_kind = KIND_ELEMENT;
            put_header(rec);
            rec.address = {8'h00, elem_idx};
            rec.value = elem_val;
            rec.last = !fe;
            due_records.push_back(rec);
            elem_idx++;
        end

        if (byte_count != '1) byte_count++;

        if (fe) begin
            total = byte_count;
            rec = '0;
            rec.record_kind = KIND_SUMMARY;
            put_header(rec);
            if (byte_count < MIN_FRAME_BYTES) rec.status = ST_TOO_SHORT;
            else if (proto_id != '0) rec.status = ST_BAD_PROTOCOL;
            else if (total != 32'(MBAP_PREFIX_BYTES) + 32'(mbap_len)) rec.status = ST_LEN_MISMATCH;
            else rec.status = ST_OK;

            if (rec.status == ST_OK) begin
                if (fcode >= FC_EXCEPTION_BASE) begin
                    rec.exception_code = count_byte;
                end else begin
                    case (fcode)
                        FC_READ_COILS, FC_READ_INPUTS:
                            rec.data_length = {5'b0, count_byte, 3'b0};
                        FC_READ_HOLDING, FC_READ_INPUT_REGS:
                            rec.data_length = {9'b0, count_byte[7:1]};
                        FC_WRITE_COIL: begin
                            rec.address = addr_word;
                            rec.value = data_word;
                            rec.value_class = (data_word == COIL_ON_VALUE) ?
                                              CLASS_ON_FAULT : CLASS_OFF_NORMAL;
                        end
                        FC_WRITE_REG: begin
                            rec.address = addr_word;
                            rec.value = data_word;
                        end
                        FC_READ_EXC_STATUS: begin
                            rec.value = {8'h00, count_byte};
                            if (count_byte == 8'h00) rec.value_class = CLASS_OFF_NORMAL;
                            else if (count_byte == DIAG_FAULT_VALUE) rec.value_class = CLASS_ON_FAULT;
                            else rec.value_class = CLASS_UNKNOWN;
                        end
                        FC_WRITE_COILS, FC_WRITE_REGS: begin
                            rec.address = addr_word;
                            rec.data_length = data_word;
                        end
                        default: ;
                    endcase
                end
            end
            rec.last = 1'b1;
            due_records.push_back(rec);
            start_frame();
        end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function void match_record(t_rec got);
        t_rec want;
        if (due_records.size() == 0) begin
            $error("record of kind %0d arrived with none outstanding", got.record_kind);
            mismatches++;
        end else begin
            want = due_records.pop_front();
            compare_field("record_kind", want.record_kind, got.record_kind);
            compare_field("status", want.status, got.status);
            compare_field("transaction_id", want.transaction_id, got.transaction_id);
            compare_field("pdu_length", want.pdu_length, got.pdu_length);
            compare_field("unit_id", want.unit_id, got.unit_id);
            compare_field("function_code", want.function_code, got.function_code);
            compare_field("exception_code", want.exception_code, got.exception_code);
            compare_field("address", want.address, got.address);
            compare_field("value", want.value, got.value);
            compare_field("data_length", want.data_length, got.data_length);
            compare_field("value_class", want.value_class, got.value_class);
            compare_field("last", want.last, got.last);
        end
    endfunction
endclass

module tb;
    localparam int unsigned CYCLE_LIMIT      = 2_000_000;
    localparam int unsigned RANDOM_BYTES     = 1700;
    localparam int unsigned CALM_BYTES       = 250;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_data_byte;
    logic        i_frame_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_record_kind;
    logic [1:0]  o_status;
    logic [15:0] o_transaction_id;
    logic [15:0] o_pdu_length;
    logic [7:0]  o_unit_id;
    logic [7:0]  o_function_code;
    logic [7:0]  o_exception_code;
    logic [15:0] o_address;
    logic [15:0] o_value;
    logic [15:0] o_data_length;
    logic [1:0]  o_value_class;
    logic        o_last;
    t_rec        seen_rec;

    mbap_checker board = new();

    logic [7:0]  pdu[$];
    logic [7:0]  frame_bytes[$];
    int unsigned in_idle_pct;
    int unsigned out_idle_pct;
    int unsigned cycles;

    modbus_tcp_frame_parser_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_frame_end     (i_frame_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_record_kind   (o_record_kind),
        .o_status        (o_status),
        .o_transaction_id(o_transaction_id),
        .o_pdu_length    (o_pdu_length),
        .o_unit_id       (o_unit_id),
        .o_function_code (o_function_code),
        .o_exception_code(o_exception_code),
        .o_address       (o_address),
        .o_value         (o_value),
        .o_data_length   (o_data_length),
        .o_value_class   (o_value_class),
        .o_last          (o_last)
    );

    assign seen_rec = {o_record_kind, o_status, o_transaction_id, o_pdu_length, o_unit_id,
                       o_function_code, o_exception_code, o_address, o_value, o_data_length,
                       o_value_class, o_last};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) board.take_byte(i_data_byte, i_frame_end);
        if (i_rst_n && o_out_valid && !i_out_stall) board.match_record(seen_rec);
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver back-pressure in bursts.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_in_valid  <= 1'b1;
            i_data_byte <= frame_bytes[i];
            i_frame_end <= (i == frame_bytes.size() - 1);
            @(posedge i_clk);
            while (o_in_stall) @(posedge i_clk);
        end
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned pick_pct();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 8;
            default: return 30;
        endcase
    endfunction

    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 10))
            0: return FC_READ_COILS;
            1: return FC_READ_INPUTS;
            2: return FC_READ_HOLDING;
            3: return FC_READ_INPUT_REGS;
            4: return FC_WRITE_COIL;
            5: return FC_WRITE_REG;
            6: return FC_READ_EXC_STATUS;
            7: return FC_WRITE_COILS;
            8: return FC_WRITE_REGS;
            9: return 8'($urandom_range(32'(FC_EXCEPTION_BASE), 255));
            default: return 8'($urandom_range(0, 32'(FC_EXCEPTION_BASE) - 1));
        endcase
    endfunction

    task automatic push_word(logic [15:0] w);
        pdu.push_back(w[15:8]);
        pdu.push_back(w[7:0]);
    endtask

    // Payload after the function code.
    task automatic make_pdu(logic [7:0] fc);
        int unsigned cnt;
        int unsigned n;
        logic [15:0] w;
        pdu.delete();
        case (fc)
            FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT_REGS: begin
                cnt = ($urandom_range(0, 15) == 0) ? 255 : $urandom_range(0, 12);
                if (cnt == 255) n = $urandom_range(0, 30);
                else if ($urandom_range(0, 3) == 0) n = $urandom_range(0, cnt + 3);
                else n = cnt;
                pdu.push_back(8'(cnt));
                repeat (n) pdu.push_back(8'($urandom));
            end
            FC_WRITE_COIL: begin
                push_word(pick_word());
                case ($urandom_range(0, 2))
                    0: w = COIL_ON_VALUE;
                    1: w = 16'h0000;
                    default: w = pick_word();
                endcase
                push_word(w);
            end
            FC_WRITE_REG: begin
                push_word(pick_word());
                push_word(pick_word());
            end
            FC_READ_EXC_STATUS: begin
                case ($urandom_range(0, 2))
                    0: pdu.push_back(8'h00);
                    1: pdu.push_back(DIAG_FAULT_VALUE);
                    default: pdu.push_back(8'($urandom));
                endcase
            end
            FC_WRITE_COILS, FC_WRITE_REGS: begin
                push_word(pick_word());
                push_word(pick_word());
                cnt = $urandom_range(0, 6);
                pdu.push_back(8'(cnt));
                repeat (cnt) pdu.push_back(8'($urandom));
            end
            default: repeat ($urandom_range(0, 4)) pdu.push_back(8'($urandom));
        endcase
        // Some frames stop early; their missing fields read as zero.
        if (pdu.size() > 0 && $urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, pdu.size())) void'(pdu.pop_back());
    endtask

    task automatic wrap_pdu(logic [7:0] fc, logic [15:0] proto, int len_skew, int keep);
        logic [15:0] txn;
        logic [15:0] len;
        txn = pick_word();
        len = 16'(2 + pdu.size() + len_skew);
        frame_bytes.delete();
        frame_bytes.push_back(txn[15:8]);
        frame_bytes.push_back(txn[7:0]);
        frame_bytes.push_back(proto[15:8]);
        frame_bytes.push_back(proto[7:0]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
        frame_bytes.push_back(8'($urandom));
        frame_bytes.push_back(fc);
        foreach (pdu[i]) frame_bytes.push_back(pdu[i]);
        while (keep > 0 && frame_bytes.size() > keep) void'(frame_bytes.pop_back());
    endtask

    initial begin
        int unsigned rand_bytes;
        int unsigned frames;
        int unsigned pick;
        int          skew;
        logic [7:0]  fc;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_data_byte <= 8'h00;
        i_frame_end <= 1'b0;
        in_idle_pct = 0;
        out_idle_pct = 0;
        rand_bytes = 0;
        frames = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A lone byte, a coil write at the field extremes, and a register read
        // whose only word lands on the closing beat together with the summary.
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h06, 8'hFF, FC_WRITE_COIL,
                        8'hFF, 8'hFF, 8'hFF, 8'h00};
        send_frame();
        frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, FC_READ_HOLDING,
                        8'h02, 8'hFF, 8'h00};
        send_frame();

        while (rand_bytes < RANDOM_BYTES) begin
            if (frames % 8 == 0) begin
                in_idle_pct = pick_pct();
                out_idle_pct = pick_pct();
            end
            if (rand_bytes + CALM_BYTES > RANDOM_BYTES) begin
                in_idle_pct = 0;
                out_idle_pct = 0;
            end

            pick = $urandom_range(0, 99);
            fc = pick_code();
            make_pdu(fc);
            if (pick < 75) begin
                wrap_pdu(fc, 16'h0000, 0, 0);
            end else if (pick < 82) begin
                wrap_pdu(fc, 16'($urandom_range(1, 65535)), 0, 0);
            end else if (pick < 89) begin
                skew = $urandom_range(1, 3);
                if ($urandom_range(0, 1) == 0) skew = -skew;
                wrap_pdu(fc, 16'h0000, skew, 0);
            end else if (pick < 95) begin
                wrap_pdu(fc, ($urandom_range(0, 1) == 0) ? 16'h0000 : pick_word(), 0,
                         $urandom_range(1, 7));
            end else begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
            end
            send_frame();
            rand_bytes += frame_bytes.size();
            frames++;
        end

        i_in_valid <= 1'b0;
        while (board.due_records.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0) $display("ALL CHECKS PASSED");
        else $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ===== files.f =====
rtl/mtfp_pkg.sv
rtl/modbus_tcp_frame_parser_top.sv
test/tb.sv
